[rtl/core/fpie_pkg.sv]
`timescale 1ns / 1ps
// Package for the IEEE format packer: format selector codes, rebias constants
// and the result record passed between the packing logic and the top level.
// No dependencies.
package fpie_pkg;

  typedef enum logic [1:0] {
    ACT_SINGLE   = 2'd0,
    ACT_DOUBLE   = 2'd1,
    ACT_EXTENDED = 2'd2
  } action_t;

  localparam int unsigned EXP_W      = 16;
  localparam int unsigned MANT_W     = 64;
  localparam int unsigned HIGH_W     = 16;

  localparam int unsigned SGL_FRAC_W = 23;
  localparam int unsigned DBL_FRAC_W = 52;
  localparam int unsigned SGL_EXP_W  = 8;
  localparam int unsigned DBL_EXP_W  = 11;

  localparam logic [EXP_W:0] SGL_SHIFT = 17'(32767 - 127);
  localparam logic [EXP_W:0] SGL_MAX   = 17'(32767 - 127 + 255);
  localparam logic [EXP_W:0] DBL_SHIFT = 17'(32767 - 1023);
  localparam logic [EXP_W:0] DBL_MAX   = 17'(32767 - 1023 + 2047);
  localparam logic [EXP_W-1:0] EXT_SHIFT = 16'h4000;

  typedef struct packed {
    logic [MANT_W-1:0] packed_low;
    logic [HIGH_W-1:0] packed_high;
    logic              too_large;
  } pack_res_t;

endpackage

[rtl/core/float_pack_ieee_formats_core.sv]
`timescale 1ns / 1ps
// IEEE format packer top level: input register, packing logic, result register.
// One request is taken per cycle unless out_stall holds a full pipeline and raises in_stall.
// The packing logic is a single combinational pass between the two registers.
// Synchronous active-low reset empties both stages; payload is not reset.
// Depends on fpie_pkg and fpie_pack.
module float_pack_ieee_formats_core
  import fpie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic              in_sign_bit,
  input  logic [EXP_W-1:0]  in_biased_exponent,
  input  logic [MANT_W-1:0] in_mantissa_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MANT_W-1:0] out_packed_low,
  output logic [HIGH_W-1:0] out_packed_high,
  output logic              out_too_large
);

  logic              s1_valid_r;
  logic [1:0]        s1_action_r;
  logic              s1_sign_r;
  logic [EXP_W-1:0]  s1_exp_r;
  logic [MANT_W-1:0] s1_mant_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  pack_res_t         res_r;
  pack_res_t         res_nxt;
  logic              out_load;
  logic              s1_load;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign s1_load  = in_valid && !in_stall;
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_action_r <= in_action;
      s1_sign_r   <= in_sign_bit;
      s1_exp_r    <= in_biased_exponent;
      s1_mant_r   <= in_mantissa_bits;
    end
  end

  fpie_pack u_pack (
    .action          (s1_action_r),
    .sign_bit        (s1_sign_r),
    .biased_exponent (s1_exp_r),
    .mantissa_bits   (s1_mant_r),
    .res             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_low  = res_r.packed_low;
  assign out_packed_high = res_r.packed_high;
  assign out_too_large   = res_r.too_large;

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.too_large |-> res_r.packed_low == '0 && res_r.packed_high == '0)
    else $error("error result carries nonzero data");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_valid_r)
    else $error("item in input stage lost on transfer");

endmodule

[rtl/core/fpie_pack.sv]
`timescale 1ns / 1ps
// Combinational packing of one internal float into single, double or extended.
// Depends on fpie_pkg.
module fpie_pack
  import fpie_pkg::*;
(
  input  logic [1:0]        action,
  input  logic              sign_bit,
  input  logic [EXP_W-1:0]  biased_exponent,
  input  logic [MANT_W-1:0] mantissa_bits,
  output pack_res_t         res
);

  logic [SGL_FRAC_W:0]   sgl_sum;
  logic [EXP_W:0]        sgl_exp;
  logic [EXP_W:0]        sgl_reb;
  logic                  sgl_ok;
  logic [DBL_FRAC_W:0]   dbl_sum;
  logic [EXP_W:0]        dbl_exp;
  logic [EXP_W:0]        dbl_reb;
  logic                  dbl_ok;
  logic [EXP_W-1:0]      ext_exp;

  // Rounding adds the first dropped bit; a carry leaves the fraction at zero.
  assign sgl_sum = {1'b0, mantissa_bits[62 -: SGL_FRAC_W]} +
                   (SGL_FRAC_W + 1)'(mantissa_bits[62 - SGL_FRAC_W]);
  assign sgl_exp = {1'b0, biased_exponent} + (EXP_W + 1)'(sgl_sum[SGL_FRAC_W]);
  assign sgl_ok  = (sgl_exp >= SGL_SHIFT) && (sgl_exp <= SGL_MAX);
  assign sgl_reb = sgl_exp - SGL_SHIFT;

  assign dbl_sum = {1'b0, mantissa_bits[62 -: DBL_FRAC_W]} +
                   (DBL_FRAC_W + 1)'(mantissa_bits[62 - DBL_FRAC_W]);
  assign dbl_exp = {1'b0, biased_exponent} + (EXP_W + 1)'(dbl_sum[DBL_FRAC_W]);
  assign dbl_ok  = (dbl_exp >= DBL_SHIFT) && (dbl_exp <= DBL_MAX);
  assign dbl_reb = dbl_exp - DBL_SHIFT;

  assign ext_exp = biased_exponent - EXT_SHIFT;

  always_comb begin
    res = '0;
    case (action_t'(action))
      ACT_SINGLE: begin
        if (sgl_ok) begin
          res.packed_low = {32'd0, sign_bit, sgl_reb[SGL_EXP_W-1:0],
                            sgl_sum[SGL_FRAC_W-1:0]};
        end else begin
          res.too_large = 1'b1;
        end
      end
      ACT_DOUBLE: begin
        if (dbl_ok) begin
          res.packed_low = {sign_bit, dbl_reb[DBL_EXP_W-1:0], dbl_sum[DBL_FRAC_W-1:0]};
        end else begin
          res.too_large = 1'b1;
        end
      end
      ACT_EXTENDED: begin
        if (!ext_exp[EXP_W-1]) begin
          res.packed_low  = mantissa_bits;
          res.packed_high = {sign_bit, ext_exp[EXP_W-2:0]};
        end else begin
          res.too_large = 1'b1;
        end
      end
      default: begin
        res.too_large = 1'b1;
      end
    endcase
  end

endmodule
